[rtl/core/cgdr_pkg.sv]
// shared constants, types and command format for the character grid delta refresh core
// depends on nothing; every rtl/core file but cgdr_ram refers to it by scoped names
package cgdr_pkg;

    localparam int GRID_COLUMNS = 80;
    localparam int GRID_ROWS    = 24;
    localparam int CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int ROW_W        = 6;
    localparam int COL_W        = 7;
    localparam int CHAR_W       = 8;
    localparam int POS_W        = 9;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

    // action codes on the input stream
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_FLIP  = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_DRAW,
        CMD_FLIP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] char_code;
    } t_cmd;

endpackage

[rtl/core/cgdr_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
module cgdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/cgdr_front.sv]
// front end: classifies an input item into a grid command and drops items with no effect
// depends on cgdr_pkg
module cgdr_front (
    input  logic [1:0]                       i_action,
    input  logic signed [cgdr_pkg::POS_W-1:0] i_x_pos,
    input  logic signed [cgdr_pkg::POS_W-1:0] i_y_pos,
    input  logic [cgdr_pkg::CHAR_W-1:0]      i_char_code,
    output logic                             o_keep,
    output cgdr_pkg::t_cmd                   o_cmd
);

    logic x_on;
    logic y_on;
    logic [cgdr_pkg::ADDR_W-1:0] row_base;

    assign x_on = !i_x_pos[cgdr_pkg::POS_W-1]
        && (i_x_pos[7:0] < 8'(cgdr_pkg::GRID_COLUMNS));
    assign y_on = !i_y_pos[cgdr_pkg::POS_W-1]
        && (i_y_pos[7:0] < 8'(cgdr_pkg::GRID_ROWS));

    // row-major cell address
    assign row_base = cgdr_pkg::ADDR_W'(i_y_pos[cgdr_pkg::ROW_W-1:0])
        * cgdr_pkg::ADDR_W'(cgdr_pkg::GRID_COLUMNS);

    always_comb begin
        o_cmd.addr      = row_base + cgdr_pkg::ADDR_W'(i_x_pos[cgdr_pkg::COL_W-1:0]);
        o_cmd.char_code = i_char_code;
        o_cmd.kind      = cgdr_pkg::CMD_FLIP;
        o_keep          = 1'b0;
        case (i_action)
            cgdr_pkg::ACT_CLEAR: begin
                o_cmd.kind = cgdr_pkg::CMD_CLEAR;
                o_keep     = 1'b1;
            end
            cgdr_pkg::ACT_DRAW: begin
                o_cmd.kind = cgdr_pkg::CMD_DRAW;
                o_keep     = x_on && y_on;
            end
            cgdr_pkg::ACT_FLIP: begin
                o_cmd.kind = cgdr_pkg::CMD_FLIP;
                o_keep     = 1'b1;
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/cgdr_queue.sv]
// short command queue between the front end and the back end
// depends on cgdr_pkg
module cgdr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cgdr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cgdr_pkg::t_cmd o_cmd
);

    cgdr_pkg::t_cmd r_mem [cgdr_pkg::QUEUE_DEPTH];
    logic [cgdr_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [cgdr_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [cgdr_pkg::QCNT_W-1:0] r_count;
    logic [cgdr_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [cgdr_pkg::QPTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == cgdr_pkg::QCNT_W'(cgdr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == cgdr_pkg::QPTR_W'(cgdr_pkg::QUEUE_DEPTH - 1))
        ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == cgdr_pkg::QPTR_W'(cgdr_pkg::QUEUE_DEPTH - 1))
        ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/cgdr_back.sv]
// back end: owns both grid memories, the scan pointer and the result register
// depends on cgdr_pkg and cgdr_ram
module cgdr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  cgdr_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_init_done,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_changed,
    output logic [cgdr_pkg::ROW_W:0]    o_row_number,
    output logic [cgdr_pkg::COL_W:0]    o_col_number,
    output logic [cgdr_pkg::CHAR_W-1:0] o_cell_char,
    output logic                        o_frame_end
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FLIP
    } t_state;

    t_state r_state;
    logic [cgdr_pkg::ADDR_W-1:0] r_sweep;
    logic [cgdr_pkg::ADDR_W-1:0] r_scan;
    logic [cgdr_pkg::ROW_W-1:0]  r_row;
    logic [cgdr_pkg::COL_W-1:0]  r_col;
    logic                        r_out_valid;
    logic                        r_changed;
    logic [cgdr_pkg::ROW_W:0]    r_row_number;
    logic [cgdr_pkg::COL_W:0]    r_col_number;
    logic [cgdr_pkg::CHAR_W-1:0] r_cell_char;
    logic                        r_frame_end;

    logic sweeping;
    logic sweep_last;
    logic scan_last;
    logic col_last;
    logic out_free;
    logic flip_done;

    logic                        draw_we;
    logic [cgdr_pkg::ADDR_W-1:0] draw_waddr;
    logic [cgdr_pkg::CHAR_W-1:0] draw_wdata;
    logic                        rd_en;
    logic [cgdr_pkg::CHAR_W-1:0] draw_rdata;
    logic                        shown_we;
    logic [cgdr_pkg::ADDR_W-1:0] shown_waddr;
    logic [cgdr_pkg::CHAR_W-1:0] shown_wdata;
    logic [cgdr_pkg::CHAR_W-1:0] shown_rdata;

    assign sweeping   = (r_state == ST_INIT) || (r_state == ST_CLEAR);
    assign sweep_last = (r_sweep == cgdr_pkg::ADDR_W'(cgdr_pkg::CELL_COUNT - 1));
    assign scan_last  = (r_scan == cgdr_pkg::ADDR_W'(cgdr_pkg::CELL_COUNT - 1));
    assign col_last   = (r_col == cgdr_pkg::COL_W'(cgdr_pkg::GRID_COLUMNS - 1));
    assign out_free   = !r_out_valid || i_out_ready;
    assign flip_done  = (r_state == ST_FLIP) && out_free;

    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_init_done = (r_state != ST_INIT);

    // drawing grid: sweeps, then single-cell draws
    assign draw_we    = sweeping || (o_cmd_pop && (i_cmd.kind == cgdr_pkg::CMD_DRAW));
    assign draw_waddr = sweeping ? r_sweep : i_cmd.addr;
    assign draw_wdata = sweeping ? cgdr_pkg::BLANK_CHAR : i_cmd.char_code;

    // both grids are read at the scan pointer for a flip step
    assign rd_en = o_cmd_pop && (i_cmd.kind == cgdr_pkg::CMD_FLIP);

    // shown grid: reset sweep, then copy-back of the scanned cell
    assign shown_we    = (r_state == ST_INIT) || flip_done;
    assign shown_waddr = (r_state == ST_INIT) ? r_sweep : r_scan;
    assign shown_wdata = (r_state == ST_INIT) ? cgdr_pkg::BLANK_CHAR : draw_rdata;

    cgdr_ram #(
        .WIDTH (cgdr_pkg::CHAR_W),
        .DEPTH (cgdr_pkg::CELL_COUNT)
    ) u_draw_ram (
        .i_clk   (i_clk),
        .i_we    (draw_we),
        .i_waddr (draw_waddr),
        .i_wdata (draw_wdata),
        .i_re    (rd_en),
        .i_raddr (r_scan),
        .o_rdata (draw_rdata)
    );

    cgdr_ram #(
        .WIDTH (cgdr_pkg::CHAR_W),
        .DEPTH (cgdr_pkg::CELL_COUNT)
    ) u_shown_ram (
        .i_clk   (i_clk),
        .i_we    (shown_we),
        .i_waddr (shown_waddr),
        .i_wdata (shown_wdata),
        .i_re    (rd_en),
        .i_raddr (r_scan),
        .o_rdata (shown_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_scan      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT, ST_CLEAR: begin
                    r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
                    if (sweep_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.kind)
                            cgdr_pkg::CMD_CLEAR: r_state <= ST_CLEAR;
                            cgdr_pkg::CMD_FLIP:  r_state <= ST_FLIP;
                            default:             r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FLIP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_changed    <= (draw_rdata != shown_rdata);
                        r_row_number <= {1'b0, r_row} + 1'b1;
                        r_col_number <= {1'b0, r_col} + 1'b1;
                        r_cell_char  <= draw_rdata;
                        r_frame_end  <= scan_last;
                        // row and column track the pointer, no divide needed
                        if (scan_last) begin
                            r_scan <= '0;
                            r_row  <= '0;
                            r_col  <= '0;
                        end else begin
                            r_scan <= r_scan + 1'b1;
                            if (col_last) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_changed    = r_changed;
    assign o_row_number = r_row_number;
    assign o_col_number = r_col_number;
    assign o_cell_char  = r_cell_char;
    assign o_frame_end  = r_frame_end;

endmodule

[rtl/core/char_grid_delta_refresh_core.sv]
// Double-buffered 80x24 character grid with delta refresh. Input items are
// clear (action 0), draw a byte at signed x,y (action 1, off-grid ignored) and
// flip step (action 2); only a flip step yields a result item, giving whether
// the scanned cell changed, its 1-based row and column, the byte now shown and
// tlast on the final cell of the frame. After reset both grids are swept to
// spaces, during which s_tready stays low. A queue of two items sits behind
// the input, then the execution stage: a draw writes one cell there, a flip
// step does a registered read of both grid memories, then compare and
// copy-back, and a clear sweeps the drawing memory one cell per cycle.
// A result may wait in the output register while later draw and clear
// items proceed.
module char_grid_delta_refresh_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // x_pos[8:0], y_pos[17:9], char_code[25:18], zeros
    input  logic [1:0]  i_s_tuser,  // action[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // row_number[6:0], col_number[14:7], cell_char[22:15], zero
    output logic        o_m_tuser,  // changed[0]
    output logic        o_m_tlast
);

    cgdr_pkg::t_cmd front_cmd;
    cgdr_pkg::t_cmd queue_cmd;
    logic front_keep;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic init_done;
    logic s_accept;

    logic [cgdr_pkg::ROW_W:0]    row_number;
    logic [cgdr_pkg::COL_W:0]    col_number;
    logic [cgdr_pkg::CHAR_W-1:0] cell_char;

    assign o_s_tready = !queue_full && init_done;
    assign s_accept   = i_s_tvalid && o_s_tready;

    cgdr_front u_front (
        .i_action    (i_s_tuser),
        .i_x_pos     (i_s_tdata[8:0]),
        .i_y_pos     (i_s_tdata[17:9]),
        .i_char_code (i_s_tdata[25:18]),
        .o_keep      (front_keep),
        .o_cmd       (front_cmd)
    );

    cgdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept && front_keep),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    cgdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_valid),
        .i_cmd        (queue_cmd),
        .o_cmd_pop    (queue_pop),
        .o_init_done  (init_done),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_changed    (o_m_tuser),
        .o_row_number (row_number),
        .o_col_number (col_number),
        .o_cell_char  (cell_char),
        .o_frame_end  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, cell_char, col_number, row_number};

endmodule
